[hdl/ntwa_pkg.sv]
// ----------------------------------------------------------------------------
// ntwa_pkg
// Shared types and constants for the neighbor table with aging.
// ----------------------------------------------------------------------------
package ntwa_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  localparam logic [15:0] HDR_EXPECTED = 16'h0203;
  localparam logic [7:0]  MASTER_FLAG  = 8'h01;
  localparam logic [6:0]  MC_MAX       = 7'd127;
  localparam logic [7:0]  AGE_MAX      = 8'd255;

  typedef enum logic [1:0] {
    ACT_PROBE = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    OP_PROBE,
    OP_DROP,
    OP_TICK,
    OP_READ,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    CFG_NODE   = 3'd0,
    CFG_POWER  = 3'd1,
    CFG_BAND   = 3'd2,
    CFG_FREQ   = 3'd3,
    CFG_RATE   = 3'd4,
    CFG_EXTRA  = 3'd5,
    CFG_MASTER = 3'd6,
    CFG_AGE    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  node;
    logic [3:0]  power;
    logic [1:0]  band;
    logic [31:0] freq;
    logic [2:0]  rate;
    logic [7:0]  extra;
    logic        master;
    logic [7:0]  age_limit;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic [7:0]  node;
    logic [31:0] address;
    logic [7:0]  power;
    logic [7:0]  band;
    logic [31:0] freq;
    logic [7:0]  rate;
    logic [7:0]  extra;
    logic [7:0]  master;
    logic [47:0] mac;
    logic [5:0]  entry_index;
  } item_t;

  typedef struct packed {
    logic [7:0]  node;
    logic [31:0] address;
    logic [7:0]  power;
    logic [7:0]  band;
    logic [31:0] freq;
    logic [7:0]  rate;
    logic [7:0]  extra;
    logic [7:0]  master;
    logic [47:0] mac;
    logic [31:0] heard;
  } slot_t;

  typedef struct packed {
    logic        changed;
    logic        accepted;
    logic        entry_used;
    logic [7:0]  entry_node;
    logic [31:0] entry_address;
    logic [47:0] entry_mac;
    logic [7:0]  entry_age;
    logic        entry_reachable;
    logic [1:0]  entry_reason;
    logic [6:0]  master_total;
  } res_t;

endpackage

[hdl/ntwa_front.sv]
// ----------------------------------------------------------------------------
// ntwa_front
// Accepts input items and classifies them into queue operations.
// ----------------------------------------------------------------------------
module ntwa_front import ntwa_pkg::*; (
  input  logic        in_valid_i,
  input  logic [1:0]  action_i,
  input  logic [15:0] header_word_i,
  input  logic [7:0]  probe_node_i,
  input  logic [31:0] probe_address_i,
  input  logic [7:0]  probe_power_i,
  input  logic [7:0]  probe_band_i,
  input  logic [31:0] probe_freq_i,
  input  logic [7:0]  probe_rate_i,
  input  logic [7:0]  probe_extra_i,
  input  logic [7:0]  probe_master_i,
  input  logic [47:0] source_mac_i,
  input  logic [5:0]  entry_index_i,
  input  logic [7:0]  local_node_i,
  input  logic        q_full_i,
  output logic        in_stall_o,
  output logic        q_push_o,
  output item_t       q_item_o
);

  op_e op;

  always_comb begin
    unique case (action_e'(action_i))
      ACT_PROBE: begin
        if (header_word_i == HDR_EXPECTED && probe_node_i != local_node_i) begin
          op = OP_PROBE;
        end else begin
          op = OP_DROP;
        end
      end
      ACT_TICK: op = OP_TICK;
      ACT_READ: op = OP_READ;
      default:  op = OP_NOP;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  assign q_item_o = '{op:          op,
                      node:        probe_node_i,
                      address:     probe_address_i,
                      power:       probe_power_i,
                      band:        probe_band_i,
                      freq:        probe_freq_i,
                      rate:        probe_rate_i,
                      extra:       probe_extra_i,
                      master:      probe_master_i,
                      mac:         source_mac_i,
                      entry_index: entry_index_i};

endmodule

[hdl/ntwa_queue.sv]
// ----------------------------------------------------------------------------
// ntwa_queue
// Two-entry queue between the front and the back engine.
// ----------------------------------------------------------------------------
module ntwa_queue import ntwa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t      buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[hdl/ntwa_back.sv]
// ----------------------------------------------------------------------------
// ntwa_back
// Back engine: scans the slot memory to look up, insert, prune and count.
// ----------------------------------------------------------------------------
module ntwa_back import ntwa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  q_valid_i,
  input  item_t q_item_i,
  output logic  q_pop_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output res_t  res_o
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RDWAIT, S_OUT} state_e;

  slot_t mem [TABLE_DEPTH];
  slot_t rdata_q;

  state_e                 state_q;
  item_t                  itm_q;
  res_t                   res_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   dv_q;
  logic [IDX_W-1:0]       didx_q;
  logic                   hit_q, free_q, chg_q;
  logic [IDX_W-1:0]       hit_idx_q, free_idx_q;
  logic [6:0]             mc_q;
  logic [31:0]            cs_q;

  logic             rd_en, wr_en, finish, in_range, dvalid, match, differ;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [31:0]      age32;
  slot_t            wdata;

  assign finish   = (state_q == S_SCAN) && (cnt_q == CNT_W'(TABLE_DEPTH)) && !dv_q;
  assign in_range = (32'(itm_q.entry_index) < 32'(TABLE_DEPTH));
  assign dvalid   = valid_q[didx_q];
  assign age32    = cs_q - rdata_q.heard;

  assign match = (rdata_q.power == {4'b0, cfg_i.power}) &&
                 (rdata_q.band == {6'b0, cfg_i.band}) &&
                 (rdata_q.freq == cfg_i.freq) &&
                 (rdata_q.rate == {5'b0, cfg_i.rate}) &&
                 (rdata_q.extra == cfg_i.extra);

  assign differ = (rdata_q.address != itm_q.address) || (rdata_q.power != itm_q.power) ||
                  (rdata_q.band != itm_q.band) || (rdata_q.freq != itm_q.freq) ||
                  (rdata_q.rate != itm_q.rate) || (rdata_q.extra != itm_q.extra) ||
                  (rdata_q.master != itm_q.master) || (rdata_q.mac != itm_q.mac);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_q[IDX_W-1:0];
    if (state_q == S_SCAN && cnt_q != CNT_W'(TABLE_DEPTH)) begin
      rd_en = 1'b1;
    end else if (finish && itm_q.op == OP_READ) begin
      rd_en   = 1'b1;
      rd_addr = IDX_W'(itm_q.entry_index);
    end
  end

  assign wr_en   = finish && (itm_q.op == OP_PROBE) && (hit_q || free_q);
  assign wr_addr = hit_q ? hit_idx_q : free_idx_q;
  assign wdata   = '{node: itm_q.node, address: itm_q.address, power: itm_q.power,
                     band: itm_q.band, freq: itm_q.freq, rate: itm_q.rate,
                     extra: itm_q.extra, master: itm_q.master, mac: itm_q.mac,
                     heard: cs_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wdata;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign out_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      itm_q      <= '0;
      res_q      <= '0;
      valid_q    <= '0;
      cnt_q      <= '0;
      dv_q       <= 1'b0;
      didx_q     <= '0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      chg_q      <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
      mc_q       <= '0;
      cs_q       <= '0;
    end else begin
      dv_q   <= rd_en && (state_q == S_SCAN) && !finish;
      didx_q <= rd_addr;
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            itm_q  <= q_item_i;
            cnt_q  <= '0;
            hit_q  <= 1'b0;
            free_q <= 1'b0;
            chg_q  <= 1'b0;
            mc_q   <= {6'b0, cfg_i.master};
            res_q  <= '0;
            case (q_item_i.op)
              OP_PROBE, OP_READ: state_q <= S_SCAN;
              OP_TICK: begin
                cs_q    <= cs_q + 32'd1;
                state_q <= S_SCAN;
              end
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_SCAN: begin
          if (cnt_q != CNT_W'(TABLE_DEPTH)) cnt_q <= cnt_q + CNT_W'(1);
          if (dv_q) begin
            case (itm_q.op)
              OP_PROBE: begin
                if (dvalid && rdata_q.node == itm_q.node && !hit_q) begin
                  hit_q     <= 1'b1;
                  hit_idx_q <= didx_q;
                  chg_q     <= differ;
                end
                if (!dvalid && !free_q) begin
                  free_q     <= 1'b1;
                  free_idx_q <= didx_q;
                end
              end
              OP_TICK: begin
                if (dvalid && age32 > {24'b0, cfg_i.age_limit}) begin
                  valid_q[didx_q] <= 1'b0;
                  chg_q           <= 1'b1;
                end
              end
              OP_READ: begin
                if (dvalid && match && rdata_q.master == MASTER_FLAG && mc_q != MC_MAX) begin
                  mc_q <= mc_q + 7'd1;
                end
              end
              default: ;
            endcase
          end
          if (finish) begin
            case (itm_q.op)
              OP_PROBE: begin
                if (hit_q) begin
                  res_q.changed  <= chg_q;
                  res_q.accepted <= 1'b1;
                end else if (free_q) begin
                  valid_q[free_idx_q] <= 1'b1;
                  res_q.changed       <= 1'b1;
                  res_q.accepted      <= 1'b1;
                end
                state_q <= S_OUT;
              end
              OP_TICK: begin
                res_q.changed <= chg_q;
                state_q       <= S_OUT;
              end
              default: state_q <= S_RDWAIT;
            endcase
          end
        end
        S_RDWAIT: begin
          res_q.master_total <= mc_q;
          if (in_range && valid_q[IDX_W'(itm_q.entry_index)]) begin
            res_q.entry_used    <= 1'b1;
            res_q.entry_node    <= rdata_q.node;
            res_q.entry_address <= rdata_q.address;
            res_q.entry_mac     <= rdata_q.mac;
            res_q.entry_age     <= (age32 > 32'(AGE_MAX)) ? AGE_MAX : age32[7:0];
            if (!match) begin
              res_q.entry_reason <= 2'd1;
            end else if (mc_q == 7'd0) begin
              res_q.entry_reason <= 2'd2;
            end else if (mc_q > 7'd1) begin
              res_q.entry_reason <= 2'd3;
            end else begin
              res_q.entry_reachable <= 1'b1;
            end
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_reach_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && res_q.entry_reachable |-> res_q.master_total == 7'd1 && res_q.entry_used)
    else $error("reachable peer without a single master");

  a_probe_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && res_q.accepted |-> !res_q.entry_used && res_q.master_total == 7'd0)
    else $error("probe result carries read fields");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("scan counter overran table");

endmodule

[hdl/neighbor_table_with_aging.sv]
// ----------------------------------------------------------------------------
// neighbor_table_with_aging
// Table of discovered radio peers with probe insertion, aging and readout.
// ----------------------------------------------------------------------------
// Probe and tick: result valid after a full slot scan.
// Read: master count scan, then one entry read.
// Dropped probes and unknown actions skip the scan. One item in the back
// engine at a time; a two-entry queue takes items while it works.
// Reset clears valid bits, the second counter and registers at once.
module neighbor_table_with_aging import ntwa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] header_word_i,
  input  logic [7:0]  probe_node_i,
  input  logic [31:0] probe_address_i,
  input  logic [7:0]  probe_power_i,
  input  logic [7:0]  probe_band_i,
  input  logic [31:0] probe_freq_i,
  input  logic [7:0]  probe_rate_i,
  input  logic [7:0]  probe_extra_i,
  input  logic [7:0]  probe_master_i,
  input  logic [47:0] source_mac_i,
  input  logic [5:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        changed_o,
  output logic        accepted_o,
  output logic        entry_used_o,
  output logic [7:0]  entry_node_o,
  output logic [31:0] entry_address_o,
  output logic [47:0] entry_mac_o,
  output logic [7:0]  entry_age_o,
  output logic        entry_reachable_o,
  output logic [1:0]  entry_reason_o,
  output logic [6:0]  master_total_o
);

  cfg_t  cfg_q;
  logic  q_full, q_push, q_pop, q_valid;
  item_t q_in, q_out;
  res_t  res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{node: 8'd0, power: 4'd0, band: 2'd0, freq: 32'd0, rate: 3'd0,
                 extra: 8'd0, master: 1'b0, age_limit: 8'd3};
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_NODE:   cfg_q.node      <= cfg_data_i[7:0];
        CFG_POWER:  cfg_q.power     <= cfg_data_i[3:0];
        CFG_BAND:   cfg_q.band      <= cfg_data_i[1:0];
        CFG_FREQ:   cfg_q.freq      <= cfg_data_i;
        CFG_RATE:   cfg_q.rate      <= cfg_data_i[2:0];
        CFG_EXTRA:  cfg_q.extra     <= cfg_data_i[7:0];
        CFG_MASTER: cfg_q.master    <= cfg_data_i[0];
        CFG_AGE:    cfg_q.age_limit <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  ntwa_front u_front (
    .in_valid_i, .action_i, .header_word_i, .probe_node_i, .probe_address_i,
    .probe_power_i, .probe_band_i, .probe_freq_i, .probe_rate_i, .probe_extra_i,
    .probe_master_i, .source_mac_i, .entry_index_i,
    .local_node_i (cfg_q.node),
    .q_full_i     (q_full),
    .in_stall_o,
    .q_push_o     (q_push),
    .q_item_o     (q_in)
  );

  ntwa_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  ntwa_back u_back (
    .clk_i, .rst_ni,
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_out),
    .q_pop_o   (q_pop),
    .out_valid_o,
    .out_stall_i,
    .res_o     (res)
  );

  assign changed_o         = res.changed;
  assign accepted_o        = res.accepted;
  assign entry_used_o      = res.entry_used;
  assign entry_node_o      = res.entry_node;
  assign entry_address_o   = res.entry_address;
  assign entry_mac_o       = res.entry_mac;
  assign entry_age_o       = res.entry_age;
  assign entry_reachable_o = res.entry_reachable;
  assign entry_reason_o    = res.entry_reason;
  assign master_total_o    = res.master_total;

endmodule
